[sv/blg_pkg.sv]
// ----------------------------------------------------------------------------
// Battery level gauge package
// Shared widths, constants, op codes and the records that pass between the
// front end, the queues and the back end of the gauge.
// ----------------------------------------------------------------------------
package blg_pkg;

    localparam int OP_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 16;
    localparam int CODE_W   = 12;
    localparam int LEVEL_W  = 7;
    localparam int MIN_W    = 24;

    localparam logic [CODE_W-1:0]  CODE_HIGH    = 12'h316;
    localparam logic [CODE_W-1:0]  CODE_LOW     = 12'h24E;
    localparam logic [CODE_W-1:0]  ADC_LIMIT    = 12'd4095;
    localparam logic [TIME_W-1:0]  SETTLE_RESET = 16'd90;
    localparam logic [LEVEL_W-1:0] LEVEL_OFFSET = 7'd6;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 7'd100;

    // percent = floor(d * 100 / 94) done as d * PCT_M >> PCT_SH
    localparam int PCT_SCALE  = 100;
    localparam int PCT_DIV    = 94;
    localparam int PCT_SH     = 20;
    localparam int PCT_M      = PCT_SCALE * ((2**PCT_SH + PCT_DIV - 1) / PCT_DIV);
    localparam int PCT_PROD_W = 28;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    typedef enum logic [OP_W-1:0] {
        OP_MEASURE = 3'd0,
        OP_PRIME   = 3'd1,
        OP_CHECK   = 3'd2,
        OP_TIMEOUT = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef struct packed {
        logic meas;      // code and level windows advance
        logic set_any;   // level may be set in either direction
        logic check;
        logic timeout;
        logic tick;
        logic pwr;
        logic stat;
    } ctl_t;

    typedef struct packed {
        ctl_t              ctl;
        logic [CODE_W-1:0] code;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               charging;
        logic               complete;
        logic [CODE_W-1:0]  code;
        logic [MIN_W-1:0]   minutes;
        logic               report;
    } result_t;

endpackage

[sv/battery_level_gauge.sv]
// An accepted request passes through the request queue and the back pipeline
// registers s1 to s5 before its result is written to the result queue.
// Throughput: one request per cycle, set by the running sums of the code
// window and the level history; issue pauses only when the eight-entry
// result queue has no free credit. Reset clears all windows, sums and status,
// empties both queues and loads the settle time with 90.
// ----------------------------------------------------------------------------
// Battery level gauge
// Front end decodes requests into a short queue; the back pipeline averages
// converter codes, converts them to percent and keeps the charge status.
// ----------------------------------------------------------------------------
module battery_level_gauge #(
    parameter int CODE_TAPS  = 5,
    parameter int LEVEL_TAPS = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [blg_pkg::TIME_W-1:0]          cfg_wr_data,
    input  logic                                push,
    output logic                                full,
    input  logic [blg_pkg::OP_W-1:0]            op,
    input  logic signed [blg_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [blg_pkg::TIME_W-1:0]          uptime,
    input  logic                                hr_active,
    input  logic                                power_pin,
    input  logic                                stat_pin,
    output logic                                empty,
    input  logic                                pop,
    output logic [blg_pkg::LEVEL_W-1:0]         level_percent,
    output logic                                charging,
    output logic                                charge_complete,
    output logic [blg_pkg::CODE_W-1:0]          filtered_code,
    output logic [blg_pkg::MIN_W-1:0]           minutes_since_full,
    output logic                                report_request
);

    localparam int ITEM_W = $bits(blg_pkg::item_t);
    localparam int RES_W  = $bits(blg_pkg::result_t);

    blg_pkg::item_t   front_item;
    logic [ITEM_W-1:0] mid_dout;
    blg_pkg::item_t   mid_item;
    logic             mid_empty;
    logic             mid_take;
    blg_pkg::result_t back_res;
    logic             back_push;
    logic [RES_W-1:0] out_dout;
    blg_pkg::result_t head;
    logic             out_full;
    logic             res_taken;

    blg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .adc_sample  (adc_sample),
        .uptime      (uptime),
        .hr_active   (hr_active),
        .power_pin   (power_pin),
        .stat_pin    (stat_pin),
        .item        (front_item)
    );

    blg_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (blg_pkg::MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (full),
        .pop   (mid_take),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    assign mid_item = mid_dout;

    blg_back #(
        .CODE_TAPS  (CODE_TAPS),
        .LEVEL_TAPS (LEVEL_TAPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_item),
        .item_valid (!mid_empty),
        .item_take  (mid_take),
        .res_taken  (res_taken),
        .res_push   (back_push),
        .res        (back_res)
    );

    // credits in the back end guarantee room, so out_full never blocks a push
    blg_queue #(
        .WIDTH (RES_W),
        .DEPTH (blg_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push && !out_full),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign res_taken = pop && !empty;
    assign head      = out_dout;

    assign level_percent      = head.level;
    assign charging           = head.charging;
    assign charge_complete    = head.complete;
    assign filtered_code      = head.code;
    assign minutes_since_full = head.minutes;
    assign report_request     = head.report;

endmodule

[sv/blg_queue.sv]
// ----------------------------------------------------------------------------
// Gauge request and result queue
// Small first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module blg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[sv/blg_front.sv]
// ----------------------------------------------------------------------------
// Gauge front end
// Holds the settle time register, clamps the converter reading and decodes
// the op of each request into control flags for the back end.
// ----------------------------------------------------------------------------
module blg_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [blg_pkg::TIME_W-1:0]    cfg_wr_data,
    input  logic [blg_pkg::OP_W-1:0]      op,
    input  logic signed [blg_pkg::SAMPLE_W-1:0] adc_sample,
    input  logic [blg_pkg::TIME_W-1:0]    uptime,
    input  logic                          hr_active,
    input  logic                          power_pin,
    input  logic                          stat_pin,
    output blg_pkg::item_t                item
);

    logic [blg_pkg::TIME_W-1:0] settle_reg;
    blg_pkg::op_t               op_code;
    blg_pkg::ctl_t              ctl;
    logic [blg_pkg::CODE_W-1:0] code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= blg_pkg::SETTLE_RESET;
        end
        else if (cfg_wr_en)
        begin
            settle_reg <= cfg_wr_data;
        end
    end

    // clamp to 0..4095
    always_comb
    begin
        if (adc_sample[blg_pkg::SAMPLE_W-1])
        begin
            code = '0;
        end
        else if (adc_sample > $signed({4'b0000, blg_pkg::ADC_LIMIT}))
        begin
            code = blg_pkg::ADC_LIMIT;
        end
        else
        begin
            code = adc_sample[blg_pkg::CODE_W-1:0];
        end
    end

    assign op_code = blg_pkg::op_t'(op);

    always_comb
    begin
        ctl      = '0;
        ctl.pwr  = power_pin;
        ctl.stat = stat_pin;
        unique case (op_code)
            blg_pkg::OP_MEASURE:
            begin
                ctl.meas    = !hr_active;
                ctl.set_any = (uptime < settle_reg);
            end
            blg_pkg::OP_PRIME:
            begin
                ctl.meas    = 1'b1;
                ctl.set_any = 1'b1;
            end
            blg_pkg::OP_CHECK:   ctl.check   = 1'b1;
            blg_pkg::OP_TIMEOUT: ctl.timeout = 1'b1;
            blg_pkg::OP_TICK:    ctl.tick    = 1'b1;
            default:             ctl.meas    = 1'b0;
        endcase
    end

    assign item.ctl  = ctl;
    assign item.code = code;

endmodule

[sv/blg_back.sv]
// ----------------------------------------------------------------------------
// Gauge back end
// Five-stage pipeline: code window sum, code average, percent, level
// history sum, history average, then the status update that forms the result.
// Issue is paced by credits for the result queue, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module blg_back #(
    parameter int CODE_TAPS  = 5,
    parameter int LEVEL_TAPS = 31
) (
    input  logic             clk,
    input  logic             rst_n,
    input  blg_pkg::item_t   item,
    input  logic             item_valid,
    output logic             item_take,
    input  logic             res_taken,
    output logic             res_push,
    output blg_pkg::result_t res
);

    localparam int CODE_W  = blg_pkg::CODE_W;
    localparam int LEVEL_W = blg_pkg::LEVEL_W;
    localparam int MIN_W   = blg_pkg::MIN_W;

    localparam int CSUM_W = $clog2(4095 * CODE_TAPS + 1);
    localparam int C_SH   = CSUM_W + $clog2(CODE_TAPS) + 1;
    localparam int C_M    = (2**C_SH + CODE_TAPS - 1) / CODE_TAPS;
    localparam int CP_W   = CSUM_W + C_SH + 1;

    localparam int PSUM_W = $clog2(100 * LEVEL_TAPS + 1);
    localparam int L_SH   = PSUM_W + $clog2(LEVEL_TAPS) + 1;
    localparam int L_M    = (2**L_SH + LEVEL_TAPS - 1) / LEVEL_TAPS;
    localparam int LP_W   = PSUM_W + L_SH + 1;

    localparam int PP_W   = blg_pkg::PCT_PROD_W;
    localparam int CRED_W = $clog2(blg_pkg::OUT_DEPTH + 1);

    logic [CRED_W-1:0] credit_reg;

    logic [CODE_W-1:0]   code_win_reg  [CODE_TAPS];
    logic [LEVEL_W-1:0]  pct_win_reg   [LEVEL_TAPS];
    logic [CSUM_W-1:0]   csum_reg;
    logic [PSUM_W-1:0]   psum_reg;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s4_valid_reg, s5_valid_reg;
    blg_pkg::ctl_t       s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    logic [CSUM_W-1:0]   s1_sum_reg;
    logic [CP_W-1:0]     s2_prod_reg;
    logic [CODE_W-1:0]   s3_code_reg, s4_code_reg, s5_code_reg;
    logic [PP_W-1:0]     s3_pprod_reg;
    logic [LEVEL_W-1:0]  s4_pct_reg, s5_pct_reg;
    logic [PSUM_W-1:0]   s4_psum_reg;
    logic [LP_W-1:0]     s5_lprod_reg;

    logic [LEVEL_W-1:0]  shown_reg, shown_next;
    logic                charging_reg, charging_next;
    logic                complete_reg, complete_next;
    logic [MIN_W-1:0]    minute_reg, minute_next;
    logic [CODE_W-1:0]   last_code_reg, last_code_next;
    logic                report;

    logic [CSUM_W-1:0]   csum_next;
    logic [CODE_W-1:0]   avg_code;
    logic [CODE_W-1:0]   clamped;
    logic [CODE_W-1:0]   span;
    logic [LEVEL_W-1:0]  raw;
    logic [LEVEL_W-1:0]  above;
    logic [LEVEL_W-1:0]  pct;
    logic [PSUM_W-1:0]   psum_next;
    logic [LEVEL_W-1:0]  hist_avg;
    logic [LEVEL_W-1:0]  lvl;

    assign item_take = item_valid && (credit_reg != '0);

    // ---------------- stage 1: code window running sum ----------------
    assign csum_next = csum_reg - CSUM_W'(code_win_reg[CODE_TAPS-1]) + CSUM_W'(item.code);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= CRED_W'(blg_pkg::OUT_DEPTH);
            csum_reg   <= '0;
            for (int i = 0; i < CODE_TAPS; i++)
            begin
                code_win_reg[i] <= '0;
            end
        end
        else
        begin
            credit_reg <= credit_reg - CRED_W'(item_take) + CRED_W'(res_taken);
            if (item_take && item.ctl.meas)
            begin
                csum_reg        <= csum_next;
                code_win_reg[0] <= item.code;
                for (int i = 1; i < CODE_TAPS; i++)
                begin
                    code_win_reg[i] <= code_win_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ctl_reg  <= item.ctl;
        s1_sum_reg  <= csum_next;
        s2_ctl_reg  <= s1_ctl_reg;
        s2_prod_reg <= CP_W'(s1_sum_reg) * CP_W'(C_M);
        s3_ctl_reg  <= s2_ctl_reg;
        s3_code_reg <= avg_code;
        s3_pprod_reg <= PP_W'(above) * PP_W'(blg_pkg::PCT_M);
        s4_ctl_reg  <= s3_ctl_reg;
        s4_code_reg <= s3_code_reg;
        s4_pct_reg  <= pct;
        s4_psum_reg <= psum_next;
        s5_ctl_reg  <= s4_ctl_reg;
        s5_code_reg <= s4_code_reg;
        s5_pct_reg  <= s4_pct_reg;
        s5_lprod_reg <= LP_W'(s4_psum_reg) * LP_W'(L_M);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= item_take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 3: average code to percent ----------------
    assign avg_code = s2_prod_reg[C_SH +: CODE_W];

    always_comb
    begin
        if (avg_code < blg_pkg::CODE_LOW)
        begin
            clamped = blg_pkg::CODE_LOW;
        end
        else if (avg_code > blg_pkg::CODE_HIGH)
        begin
            clamped = blg_pkg::CODE_HIGH;
        end
        else
        begin
            clamped = avg_code;
        end
        span  = clamped - blg_pkg::CODE_LOW;
        raw   = span[LEVEL_W:1];
        above = (raw > blg_pkg::LEVEL_OFFSET) ? raw - blg_pkg::LEVEL_OFFSET : '0;
    end

    // ---------------- stage 4: level history running sum ----------------
    assign pct       = s3_pprod_reg[blg_pkg::PCT_SH +: LEVEL_W];
    assign psum_next = psum_reg - PSUM_W'(pct_win_reg[LEVEL_TAPS-1]) + PSUM_W'(pct);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psum_reg <= '0;
            for (int i = 0; i < LEVEL_TAPS; i++)
            begin
                pct_win_reg[i] <= '0;
            end
        end
        else if (s3_valid_reg && s3_ctl_reg.meas)
        begin
            psum_reg       <= psum_next;
            pct_win_reg[0] <= pct;
            for (int i = 1; i < LEVEL_TAPS; i++)
            begin
                pct_win_reg[i] <= pct_win_reg[i-1];
            end
        end
    end

    // ---------------- stage 6: status update and result ----------------
    assign hist_avg = s5_lprod_reg[L_SH +: LEVEL_W];
    assign lvl      = charging_reg ? hist_avg : s5_pct_reg;

    always_comb
    begin
        shown_next     = shown_reg;
        charging_next  = charging_reg;
        complete_next  = complete_reg;
        minute_next    = minute_reg;
        last_code_next = last_code_reg;
        report         = 1'b0;
        if (s5_valid_reg)
        begin
            if (s5_ctl_reg.meas)
            begin
                last_code_next = s5_code_reg;
                // after settle, a discharging battery only moves down
                if (s5_ctl_reg.set_any || charging_reg || (lvl <= shown_reg))
                begin
                    shown_next = lvl;
                end
            end
            if (s5_ctl_reg.check)
            begin
                if (s5_ctl_reg.pwr && s5_ctl_reg.stat)
                begin
                    complete_next = 1'b1;
                    charging_next = 1'b0;
                    minute_next   = '0;
                end
                else if (!s5_ctl_reg.pwr)
                begin
                    charging_next = 1'b0;
                end
                else
                begin
                    complete_next = 1'b0;
                    charging_next = 1'b1;
                end
            end
            if (s5_ctl_reg.timeout && (shown_reg >= blg_pkg::FULL_LEVEL))
            begin
                charging_next = 1'b0;
                report        = 1'b1;
            end
            if (s5_ctl_reg.tick)
            begin
                minute_next = minute_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_reg     <= '0;
            charging_reg  <= 1'b0;
            complete_reg  <= 1'b0;
            minute_reg    <= '0;
            last_code_reg <= '0;
        end
        else
        begin
            shown_reg     <= shown_next;
            charging_reg  <= charging_next;
            complete_reg  <= complete_next;
            minute_reg    <= minute_next;
            last_code_reg <= last_code_next;
        end
    end

    assign res_push     = s5_valid_reg;
    assign res.level    = shown_next;
    assign res.charging = charging_next;
    assign res.complete = complete_next;
    assign res.code     = last_code_next;
    assign res.minutes  = minute_next;
    assign res.report   = report;

endmodule
